// ===== src/psc_pkg.sv =====
// Shared widths, limits and register codes for the PID speed controller.
package psc_pkg;

    // Field widths
    localparam int CMD_W     = 7;
    localparam int SPD_W     = 16;
    localparam int DUTY_W    = 7;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = 17;
    localparam int INTEG_W   = 32;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int CFG_IDX_W = 2;

    // Stream widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Product and sum widths
    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int PI_W  = GAIN_W + 1 + INTEG_W;
    localparam int PD_W  = GAIN_W + 1 + DIFF_W;
    localparam int VAL_W = PI_W + 2;

    // Limits
    localparam int DUTY_MAX = 100;
    localparam int ERR_MAX  = 65535;
    localparam int ERR_MIN  = -65536;

    // Gain reset values, unsigned Q2.14
    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd4915;
    localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd246;
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd3277;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

endpackage

// ===== src/pid_speed_controller_unit.sv =====
// Positional PID speed controller with feedforward, six-stage pipeline.
//
// Channel   Dir  Beat contents (low bit first)
// s_*       in   tdata: command_percent[6:0], measured_speed[22:7], pad
// m_*       out  tdata: duty_percent[6:0], pad; tuser: duty_clamped
// cfg_*     in   cfg_index selects gain P/I/D, cfg_data is the new gain
//
// One beat per cycle in and out unless m_tready stalls the output; a result
// passes through the six register stages (input, error/integral, multiply,
// sum, range/reciprocal multiply, output).
// Reset clears the gains to their defaults, the integral and the last error.
// Each stage holds its beat while the next one is full and blocked, so a
// stalled output still lets upstream stages fill before s_tready drops.
module pid_speed_controller_unit #(
    parameter int SPEED_PER_PERCENT = 30,
    parameter int GAIN_FRAC_BITS    = 14
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command_percent[6:0], measured_speed[22:7]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [psc_pkg::S_TDATA_W-1:0]    s_tdata,
    // duty_percent[6:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [psc_pkg::M_TDATA_W-1:0]    m_tdata,
    // duty_clamped[0]
    output logic [psc_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psc_pkg::GAIN_W-1:0]       cfg_data
);
    import psc_pkg::*;

    // Target speed width and error working width
    localparam int TGT_W = $clog2(127 * SPEED_PER_PERCENT + 1);
    localparam int DW    = ((TGT_W > SPD_W) ? TGT_W : SPD_W) + 2;

    // Duty division by the speed scale through a reciprocal multiply,
    // exact for 0 <= v < LIM since 2^K >= LIM * SPEED_PER_PERCENT
    localparam int    LIM   = (DUTY_MAX + 1) * SPEED_PER_PERCENT;
    localparam int    QV_W  = $clog2(LIM);
    localparam int    K     = $clog2(LIM * SPEED_PER_PERCENT);
    localparam longint RECIP = ((64'sd1 <<< K) + SPEED_PER_PERCENT - 1) / SPEED_PER_PERCENT;
    localparam int    PR_W  = K + DUTY_W + 1;

    localparam logic signed [DW-1:0]    ERR_HI  = DW'(ERR_MAX);
    localparam logic signed [DW-1:0]    ERR_LO  = DW'(ERR_MIN);
    localparam logic signed [VAL_W-1:0] VAL_NEG = VAL_W'(-SPEED_PER_PERCENT);
    localparam logic signed [VAL_W-1:0] VAL_LIM = VAL_W'(LIM);

    // Gain registers
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;

    // Controller state
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;

    // Pipeline valid bits and ready chain
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

    // Stage payloads
    logic [CMD_W-1:0]          cmd0_reg;
    logic signed [SPD_W-1:0]   spd0_reg;
    logic [TGT_W-1:0]          tgt1_reg, tgt2_reg;
    logic signed [ERR_W-1:0]   err1_reg;
    logic signed [INTEG_W-1:0] integ1_reg;
    logic signed [DIFF_W-1:0]  diff1_reg;
    logic signed [PP_W-1:0]    pp2_reg;
    logic signed [PI_W-1:0]    pi2_reg;
    logic signed [PD_W-1:0]    pd2_reg;
    logic signed [VAL_W-1:0]   val3_reg;
    logic                      lo4_reg, hi4_reg, neg4_reg;
    logic [PR_W-1:0]           prod4_reg;
    logic [DUTY_W-1:0]         duty5_reg;
    logic                      clamp5_reg;

    // Combinational next values
    logic [TGT_W-1:0]          tgt_next;
    logic signed [DW-1:0]      err_full;
    logic signed [ERR_W-1:0]   err_sat;
    logic signed [INTEG_W:0]   isum;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [GAIN_W:0]    kp_op, ki_op, kd_op;
    logic signed [PP_W-1:0]    pp_next;
    logic signed [PI_W-1:0]    pi_next;
    logic signed [PD_W-1:0]    pd_next;
    logic signed [VAL_W-1:0]   sum_next;
    logic signed [VAL_W-1:0]   val_next;
    logic                      lo_next, hi_next;
    logic [PR_W-1:0]           prod_next;
    logic [DUTY_W-1:0]         duty_next;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= GAIN_P_RESET;
            gain_i_reg <= GAIN_I_RESET;
            gain_d_reg <= GAIN_D_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gain_p_reg <= cfg_data;
                REG_GAIN_I: gain_i_reg <= cfg_data;
                REG_GAIN_D: gain_d_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Ready chain: a stage takes a beat when empty or when it drains
    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 0: input register
    always_ff @(posedge clk)
    begin
        if (rdy0 && s_tvalid)
        begin
            cmd0_reg <= s_tdata[CMD_W-1:0];
            spd0_reg <= $signed(s_tdata[CMD_W +: SPD_W]);
        end
    end

    // Stage 1: target, saturated error, saturated integral, difference
    always_comb
    begin
        tgt_next = TGT_W'(cmd0_reg * SPEED_PER_PERCENT);
        err_full = $signed({{(DW-TGT_W){1'b0}}, tgt_next}) - DW'(spd0_reg);
        if (err_full > ERR_HI)
            err_sat = ERR_W'(ERR_MAX);
        else if (err_full < ERR_LO)
            err_sat = ERR_W'(ERR_MIN);
        else
            err_sat = err_full[ERR_W-1:0];

        isum = (INTEG_W+1)'(integral_reg) + (INTEG_W+1)'(err_sat);
        // overflow when the two top bits differ
        if (isum[INTEG_W] != isum[INTEG_W-1])
            integ_next = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            integ_next = isum[INTEG_W-1:0];

        diff_next = DIFF_W'(err_sat) - DIFF_W'(prev_err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else if (rdy1 && v0_reg)
        begin
            integral_reg <= integ_next;
            prev_err_reg <= err_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && v0_reg)
        begin
            tgt1_reg   <= tgt_next;
            err1_reg   <= err_sat;
            integ1_reg <= integ_next;
            diff1_reg  <= diff_next;
        end
    end

    // Stage 2: gain products
    assign kp_op   = $signed({1'b0, gain_p_reg});
    assign ki_op   = $signed({1'b0, gain_i_reg});
    assign kd_op   = $signed({1'b0, gain_d_reg});
    assign pp_next = kp_op * err1_reg;
    assign pi_next = ki_op * integ1_reg;
    assign pd_next = kd_op * diff1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            tgt2_reg <= tgt1_reg;
            pp2_reg  <= pp_next;
            pi2_reg  <= pi_next;
            pd2_reg  <= pd_next;
        end
    end

    // Stage 3: sum, floor shift, feedforward add
    assign sum_next = VAL_W'(pp2_reg) + VAL_W'(pi2_reg) + VAL_W'(pd2_reg);
    assign val_next = (sum_next >>> GAIN_FRAC_BITS)
                    + $signed({{(VAL_W-TGT_W){1'b0}}, tgt2_reg});

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
            val3_reg <= val_next;
    end

    // Stage 4: range check and reciprocal multiply
    // truncated quotient is negative only for v <= -scale
    assign lo_next   = (val3_reg <= VAL_NEG);
    assign hi_next   = (val3_reg >= VAL_LIM);
    assign prod_next = PR_W'(val3_reg[QV_W-1:0]) * PR_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            lo4_reg   <= lo_next;
            hi4_reg   <= hi_next;
            neg4_reg  <= val3_reg[VAL_W-1];
            prod4_reg <= prod_next;
        end
    end

    // Stage 5: duty select and output register
    // a small negative value truncates to zero and is not flagged
    always_comb
    begin
        if (lo4_reg)
            duty_next = '0;
        else if (hi4_reg)
            duty_next = DUTY_W'(DUTY_MAX);
        else if (neg4_reg)
            duty_next = '0;
        else
            duty_next = prod4_reg[K +: DUTY_W];
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            duty5_reg  <= duty_next;
            clamp5_reg <= lo4_reg || hi4_reg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {{(M_TDATA_W-DUTY_W){1'b0}}, duty5_reg};
    assign m_tuser  = clamp5_reg;

endmodule

// ===== src/psc_checker.sv =====
// Port-level checks for the PID speed controller output stream.
module psc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [psc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [psc_pkg::M_TUSER_W-1:0] m_tuser
);
    import psc_pkg::*;

    // Reset empties the output stage
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    // Duty never leaves its range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[DUTY_W-1:0] <= DUTY_W'(DUTY_MAX))
        else $error("duty above limit");

    // A clamped duty sits at one of the two bounds
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[DUTY_W-1:0] == '0) || (m_tdata[DUTY_W-1:0] == DUTY_W'(DUTY_MAX)))
        else $error("clamp flag without bound duty");

endmodule

bind pid_speed_controller_unit psc_checker u_psc_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the PID speed controller: driver, monitor, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int SPEED_PER_PERCENT = 30;
    localparam int GAIN_FRAC_BITS    = 14;
    // Input beat to output beat through the pipeline
    localparam int LATENCY           = 5;

    // Index past the last gain register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint INTEG_HI = 64'sd2147483647;
    localparam longint INTEG_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [SPD_W-1:0] speed;
        logic [CMD_W-1:0]        cmd;
    } ctrl_tick_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              clamped;
    } duty_beat_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // DUT ports, all inputs known from time zero
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data  = '0;

    pid_speed_controller_unit #(
        .SPEED_PER_PERCENT (SPEED_PER_PERCENT),
        .GAIN_FRAC_BITS    (GAIN_FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pending ticks and the duties they should produce
    ctrl_tick_t tick_q[$];
    duty_beat_t duty_q[$];
    int         mismatch_count = 0;
    int         beat_count     = 0;

    // Pacing knobs, changed between phases
    int          burst_max = 8;
    int          gap_max   = 4;
    logic [15:0] ready_pat = 16'hFFFF;

    // Predictor state: gains, error integral and last error
    logic [GAIN_W-1:0] gain_p   = GAIN_P_RESET;
    logic [GAIN_W-1:0] gain_i   = GAIN_I_RESET;
    logic [GAIN_W-1:0] gain_d   = GAIN_D_RESET;
    int                err_sum  = 0;
    int                last_err = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // One control tick: update integral and last error, return the new duty
    function automatic duty_beat_t pid_tick(input logic [CMD_W-1:0] cmd,
                                            input logic signed [SPD_W-1:0] spd);
        longint     target;
        longint     err;
        longint     integ;
        longint     diff;
        longint     total;
        longint     corr;
        longint     duty;
        duty_beat_t r;
        target = longint'(cmd) * SPEED_PER_PERCENT;
        err    = target - longint'(spd);
        // Cannot trip with 30 speed units per percent, kept for other scalings
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < ERR_MIN) err = ERR_MIN;
        integ = longint'(err_sum) + err;
        if (integ > INTEG_HI) integ = INTEG_HI;
        if (integ < INTEG_LO) integ = INTEG_LO;
        diff  = err - longint'(last_err);
        total = longint'(gain_p) * err + longint'(gain_i) * integ
              + longint'(gain_d) * diff;
        // Arithmetic shift floors; the divide truncates toward zero
        corr  = total >>> GAIN_FRAC_BITS;
        duty  = (target + corr) / SPEED_PER_PERCENT;
        r.clamped = 1'b0;
        if (duty < 0) begin
            duty      = 0;
            r.clamped = 1'b1;
        end else if (duty > DUTY_MAX) begin
            duty      = DUTY_MAX;
            r.clamped = 1'b1;
        end
        r.duty   = DUTY_W'(duty);
        err_sum  = int'(integ);
        last_err = int'(err);
        return r;
    endfunction

    // Driver: bursts of beats with random gaps
    ctrl_tick_t drv_tick;
    int         beats_left = 1;
    int         idle_left  = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (idle_left > 0 || tick_q.size() == 0) begin
                if (idle_left > 0)
                    idle_left--;
                s_tvalid <= 1'b0;
            end else begin
                drv_tick = tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, drv_tick.speed, drv_tick.cmd};
                beats_left--;
                if (beats_left <= 0) begin
                    beats_left = $urandom_range(1, burst_max);
                    idle_left  = $urandom_range(0, gap_max);
                end
            end
        end
    end

    // Receiver: ready follows a rotating stall pattern
    logic [3:0] pat_pos = '0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            pat_pos  <= '0;
        end else begin
            m_tready <= ready_pat[pat_pos];
            pat_pos  <= pat_pos + 4'd1;
        end
    end

    // Monitor and scoreboard
    duty_beat_t want;

    always @(posedge clk) begin
        if (rst_n) begin
            // Check output beats first so a same-edge input cannot satisfy them
            if (m_tvalid && m_tready) begin
                if (duty_q.size() == 0) begin
                    report_mismatch($sformatf("beat %0d unexpected, duty %0d clamp %0b",
                                              beat_count, m_tdata[DUTY_W-1:0], m_tuser[0]));
                end else begin
                    want = duty_q.pop_front();
                    if (m_tdata[DUTY_W-1:0] !== want.duty)
                        report_mismatch($sformatf("beat %0d duty %0d, want %0d",
                                                  beat_count, m_tdata[DUTY_W-1:0], want.duty));
                    if (m_tuser[0] !== want.clamped)
                        report_mismatch($sformatf("beat %0d clamp %0b, want %0b",
                                                  beat_count, m_tuser[0], want.clamped));
                end
                beat_count++;
            end
            // Gain writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAIN_P: gain_p = cfg_data;
                    REG_GAIN_I: gain_i = cfg_data;
                    REG_GAIN_D: gain_d = cfg_data;
                    default: ;
                endcase
            end
            // Accepted input beats
            if (s_tvalid && s_tready)
                duty_q.push_back(pid_tick(s_tdata[CMD_W-1:0],
                                          $signed(s_tdata[CMD_W+SPD_W-1:CMD_W])));
        end
    end

    function automatic ctrl_tick_t make_tick(input int cmd, input int spd);
        ctrl_tick_t t;
        if (spd > 32767) spd = 32767;
        if (spd < -32768) spd = -32768;
        t.cmd   = CMD_W'(cmd);
        t.speed = SPD_W'(spd);
        return t;
    endfunction

    // Mostly speeds near target so the duty lands near the command; a quarter of commands lie above 100
    function automatic ctrl_tick_t random_tick();
        int pick;
        int cmd;
        int spd;
        pick = $urandom_range(0, 3);
        cmd  = (pick == 3) ? $urandom_range(101, 127) : $urandom_range(0, 100);
        case (pick)
            0:       spd = int'($urandom_range(0, 65535)) - 32768;
            1:       spd = cmd * SPEED_PER_PERCENT + int'($urandom_range(0, 6000)) - 3000;
            default: spd = cmd * SPEED_PER_PERCENT + int'($urandom_range(0, 400)) - 200;
        endcase
        return make_tick(cmd, spd);
    endfunction

    task automatic push_random(input int n);
        repeat (n) tick_q.push_back(random_tick());
    endtask

    // Pacing for the next phase; a quarter of phases run without idling
    task automatic shuffle_pacing();
        if ($urandom_range(0, 3) == 0) begin
            burst_max = 64;
            gap_max   = 0;
            ready_pat = 16'hFFFF;
        end else begin
            burst_max = $urandom_range(1, 12);
            gap_max   = $urandom_range(1, 8);
            ready_pat = 16'($urandom()) | 16'h0001;
        end
    endtask

    // Block idle: nothing queued, nothing in flight
    task automatic wait_idle();
        while (tick_q.size() != 0 || s_tvalid || duty_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                             input logic [GAIN_W-1:0] d);
        wait_idle();
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        shuffle_pacing();
    endtask

    // Stimulus sequence
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset gains: field extremes, exact targets, both duty saturations
        tick_q.push_back(make_tick(0, 0));
        tick_q.push_back(make_tick(100, 3000));
        tick_q.push_back(make_tick(127, -32768));
        tick_q.push_back(make_tick(0, 32767));
        tick_q.push_back(make_tick(127, 32767));
        tick_q.push_back(make_tick(0, -32768));
        tick_q.push_back(make_tick(50, 1500));
        tick_q.push_back(make_tick(101, 3030));
        tick_q.push_back(make_tick(1, 29));
        tick_q.push_back(make_tick(100, 2990));
        tick_q.push_back(make_tick(64, 1920));
        tick_q.push_back(make_tick(99, 2970));
        push_random(100);

        // Zero gains: duty equals the command up to 100, 0 and 100 exact are not flagged
        set_gains(16'd0, 16'd0, 16'd0);
        tick_q.push_back(make_tick(0, 0));
        tick_q.push_back(make_tick(100, 1234));
        tick_q.push_back(make_tick(101, 0));
        tick_q.push_back(make_tick(127, -32768));
        tick_q.push_back(make_tick(0, 32767));
        push_random(90);

        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_random(90);

        set_gains(16'hFFFF, 16'd0, 16'd0);
        push_random(90);

        // Write to the unused index must leave the gains alone
        set_gains(16'd0, 16'd0, 16'hFFFF);
        write_reg(REG_UNUSED, 16'($urandom()));
        push_random(90);

        set_gains(16'($urandom()), 16'($urandom_range(0, 2000)), 16'($urandom()));
        push_random(90);

        set_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
        push_random(90);

        // Integral windup with a unit integral gain, then unwinding past zero
        set_gains(16'd0, 16'd1, 16'd0);
        burst_max = 200;
        gap_max   = 1;
        ready_pat = 16'hFFEF;
        repeat (20) tick_q.push_back(make_tick(127, -32768));
        repeat (30) tick_q.push_back(make_tick(0, 32767));

        // Default gains on top of a wound-up integral
        set_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
        push_random(60);

        wait_idle();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
